>>> src/assert_macros.svh
// Assertion macros used by the RTL file of the JSON string unescaper.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property at every rising clock edge outside of reset.
`define JSU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checks that a condition never holds outside of reset.
`define JSU_ASSERT_NEVER(lbl, cond, msg) \
  `JSU_ASSERT(lbl, !(cond), msg)

`endif

>>> src/jsu_pkg.sv
// Package with constants, types and helper functions of the JSON string unescaper.
package jsu_pkg;

  localparam logic [7:0] ChBackslash = 8'h5C;
  localparam logic [7:0] ChU         = 8'h75;
  localparam logic [7:0] ChB         = 8'h62;
  localparam logic [7:0] ChF         = 8'h66;
  localparam logic [7:0] ChN         = 8'h6E;
  localparam logic [7:0] ChR         = 8'h72;
  localparam logic [7:0] ChT         = 8'h74;
  localparam logic [7:0] ChQuote     = 8'h22;
  localparam logic [3:0] HexTen      = 4'd10;

  localparam int unsigned MaxResults = 3;

  typedef struct packed {
    logic [MaxResults-1:0][7:0] bytes;
    logic [1:0]                 count;
  } utf8_t;

  function automatic logic [3:0] hex_value(input logic [7:0] b);
    logic [3:0] v;
    v = 4'd0;
    if (b >= 8'h30 && b <= 8'h39) begin
      v = b[3:0];
    end else if (b >= 8'h41 && b <= 8'h46) begin
      v = 4'(b[3:0] - 4'd1) + HexTen;
    end else if (b >= 8'h61 && b <= 8'h66) begin
      v = 4'(b[3:0] - 4'd1) + HexTen;
    end
    return v;
  endfunction

  function automatic logic [7:0] map_escape(input logic [7:0] b);
    logic [7:0] r;
    case (b)
      ChB:     r = 8'h08;
      ChF:     r = 8'h0C;
      ChN:     r = 8'h0A;
      ChR:     r = 8'h0D;
      ChT:     r = 8'h09;
      default: r = b;
    endcase
    return r;
  endfunction

  function automatic utf8_t code_point_bytes(input logic [15:0] cp);
    utf8_t r;
    r.bytes = '0;
    if (cp < 16'h0080) begin
      r.bytes[0] = cp[7:0];
      r.count    = 2'd1;
    end else if (cp < 16'h0800) begin
      r.bytes[0] = {3'b110, cp[10:6]};
      r.bytes[1] = {2'b10, cp[5:0]};
      r.count    = 2'd2;
    end else begin
      r.bytes[0] = {4'b1110, cp[15:12]};
      r.bytes[1] = {2'b10, cp[11:6]};
      r.bytes[2] = {2'b10, cp[5:0]};
      r.count    = 2'd3;
    end
    return r;
  endfunction

endpackage

>>> src/jsu_in_if.sv
// Input channel interface carrying one raw string byte per word.
interface jsu_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

>>> src/jsu_out_if.sv
// Output channel interface carrying one unescaped result per word.
interface jsu_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_valid;
  logic       out_last;
  logic       truncated;

  modport source (output valid, output out_byte, output out_valid, output out_last,
                  output truncated, input ready);
  modport sink   (input valid, input out_byte, input out_valid, input out_last,
                  input truncated, output ready);
endinterface

>>> src/json_string_unescaper.sv
// JSON string unescaper: decodes escapes and \u code points of a string body into bytes.
// The input channel takes one raw byte of a JSON string body per word, with in_last
// marking the final byte of the string. The output channel gives one unescaped byte
// per word; a \u escape gives one to three UTF-8 bytes. A string that ends inside an
// escape closes with a single word that has out_valid low and truncated high.
// An accepted byte updates the escape state and loads its results into a result
// buffer at the same edge, so the first result is offered in the cycle after acceptance.
// Plain bytes and simple escapes flow at one word per cycle in both directions while
// the receiver is ready. A byte that completes a \u escape occupies the output with one
// word per UTF-8 byte, since the result buffer drives one word per cycle. A new byte is
// taken while the final word of the buffer is being taken.
// An opening backslash or one of the first three hex digits yields no word, unless last.
// When the receiver stalls, the buffer holds its word and input stalls once the
// buffer cannot be emptied in the same cycle.
// Reset clears the escape state and empties the result buffer; after the last byte
// of a string the escape state also returns to its reset value.
`include "assert_macros.svh"

module json_string_unescaper (
  input  logic             clk_i,
  input  logic             rst_ni,
  jsu_in_if.sink           in_i,
  jsu_out_if.source        out_o
);

  logic        esc_q, esc_d;
  logic        hex_q, hex_d;
  logic [1:0]  cnt_q, cnt_d;
  logic [15:0] acc_q, acc_d;

  logic [jsu_pkg::MaxResults-1:0][7:0] buf_q, buf_d;
  logic [1:0]  num_q, num_d;
  logic [1:0]  pos_q, pos_d;
  logic        full_q, full_d;
  logic        last_q, last_d;
  logic        trunc_q, trunc_d;

  logic        accept;
  logic        pop;
  logic        pop_last;
  logic        at_last;
  logic [15:0] acc_shift;
  logic [1:0]  new_num;
  logic [jsu_pkg::MaxResults-1:0][7:0] new_buf;
  logic        new_trunc;
  jsu_pkg::utf8_t enc;

  assign at_last  = (pos_q == 2'(num_q - 2'd1));
  assign pop      = full_q && out_o.ready;
  assign pop_last = pop && at_last;
  assign in_i.ready = !full_q || pop_last;
  assign accept   = in_i.valid && in_i.ready;

  assign acc_shift = {acc_q[11:0], jsu_pkg::hex_value(in_i.in_byte)};
  assign enc       = jsu_pkg::code_point_bytes(acc_shift);

  always_comb begin
    esc_d     = esc_q;
    hex_d     = hex_q;
    cnt_d     = cnt_q;
    acc_d     = acc_q;
    new_num   = 2'd0;
    new_buf   = '0;
    new_trunc = 1'b0;
    if (hex_q) begin
      acc_d = acc_shift;
      cnt_d = 2'(cnt_q + 2'd1);
      if (cnt_q == 2'd3) begin
        new_buf = enc.bytes;
        new_num = enc.count;
        hex_d   = 1'b0;
        cnt_d   = 2'd0;
        acc_d   = '0;
      end
    end else if (esc_q) begin
      esc_d = 1'b0;
      if (in_i.in_byte == jsu_pkg::ChU) begin
        hex_d = 1'b1;
        cnt_d = 2'd0;
        acc_d = '0;
      end else begin
        new_buf[0] = jsu_pkg::map_escape(in_i.in_byte);
        new_num    = 2'd1;
      end
    end else if (in_i.in_byte == jsu_pkg::ChBackslash) begin
      esc_d = 1'b1;
    end else begin
      new_buf[0] = in_i.in_byte;
      new_num    = 2'd1;
    end
    if (in_i.in_last) begin
      if (esc_d || hex_d) begin
        new_buf   = '0;
        new_num   = 2'd1;
        new_trunc = 1'b1;
      end
      esc_d = 1'b0;
      hex_d = 1'b0;
      cnt_d = 2'd0;
      acc_d = '0;
    end
  end

  always_comb begin
    full_d  = full_q;
    pos_d   = pos_q;
    buf_d   = buf_q;
    num_d   = num_q;
    last_d  = last_q;
    trunc_d = trunc_q;
    if (pop) begin
      if (at_last) begin
        full_d = 1'b0;
      end else begin
        pos_d = 2'(pos_q + 2'd1);
      end
    end
    if (accept && new_num != 2'd0) begin
      full_d  = 1'b1;
      pos_d   = 2'd0;
      buf_d   = new_buf;
      num_d   = new_num;
      last_d  = in_i.in_last;
      trunc_d = new_trunc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      esc_q  <= 1'b0;
      hex_q  <= 1'b0;
      cnt_q  <= 2'd0;
      acc_q  <= '0;
      full_q <= 1'b0;
      pos_q  <= 2'd0;
      num_q  <= 2'd1;
    end else begin
      if (accept) begin
        esc_q <= esc_d;
        hex_q <= hex_d;
        cnt_q <= cnt_d;
        acc_q <= acc_d;
      end
      full_q <= full_d;
      pos_q  <= pos_d;
      num_q  <= num_d;
    end
  end

  always_ff @(posedge clk_i) begin
    buf_q   <= buf_d;
    last_q  <= last_d;
    trunc_q <= trunc_d;
  end

  always_comb begin
    case (pos_q)
      2'd0:    out_o.out_byte = buf_q[0];
      2'd1:    out_o.out_byte = buf_q[1];
      2'd2:    out_o.out_byte = buf_q[2];
      default: out_o.out_byte = buf_q[0];
    endcase
  end

  assign out_o.valid     = full_q;
  assign out_o.out_valid = !trunc_q;
  assign out_o.out_last  = last_q && at_last;
  assign out_o.truncated = trunc_q;

  `JSU_ASSERT(a_trunc_alone, (full_q && trunc_q) |-> (num_q == 2'd1 && last_q), "bad trunc word")
  `JSU_ASSERT(a_accept_full, (accept && full_q) |-> pop_last, "accept while busy")
  `JSU_ASSERT_NEVER(a_esc_hex, esc_q && hex_q, "escape and hex mode active together")
  `JSU_ASSERT(a_hex_idle, !hex_q |-> (cnt_q == 2'd0 && acc_q == 16'd0), "stale hex state")

endmodule

>>> sim/json_string_unescaper_test.sv
// Self-checking testbench for the JSON string unescaper: a directed table, then random strings.
`timescale 1ns / 100ps

module json_string_unescaper_test;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_valid;
    logic       out_last;
    logic       truncated;
  } result_word_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } raw_word_t;

  typedef struct packed {
    logic [7:0]   in_byte;
    logic         in_last;
    logic         typed;
    result_word_t typed_word;
  } stim_row_t;

  localparam int unsigned RandomItems    = 145;
  localparam int unsigned TailItems      = 30;
  localparam int unsigned LongHoldCycles = 50;
  localparam int unsigned DrainLimit     = 5000;

  localparam result_word_t NoWord    = '0;
  localparam result_word_t TruncWord = '{out_byte: 8'h00, out_valid: 1'b0, out_last: 1'b1,
                                         truncated: 1'b1};

  localparam logic [7:0] EscapeLetters [7] = '{
    jsu_pkg::ChB, jsu_pkg::ChF, jsu_pkg::ChN, jsu_pkg::ChR, jsu_pkg::ChT,
    jsu_pkg::ChBackslash, jsu_pkg::ChQuote
  };

  localparam stim_row_t DirectedRows [25] = '{
    '{8'h00,                1'b0, 1'b1, '{8'h00, 1'b1, 1'b0, 1'b0}},
    '{8'hFF,                1'b1, 1'b1, '{8'hFF, 1'b1, 1'b1, 1'b0}},
    '{jsu_pkg::ChBackslash, 1'b0, 1'b0, NoWord},
    '{jsu_pkg::ChB,         1'b0, 1'b0, NoWord},
    '{jsu_pkg::ChBackslash, 1'b0, 1'b0, NoWord},
    '{jsu_pkg::ChF,         1'b0, 1'b0, NoWord},
    '{jsu_pkg::ChBackslash, 1'b0, 1'b0, NoWord},
    '{jsu_pkg::ChN,         1'b0, 1'b0, NoWord},
    '{jsu_pkg::ChBackslash, 1'b0, 1'b0, NoWord},
    '{jsu_pkg::ChR,         1'b0, 1'b0, NoWord},
    '{jsu_pkg::ChBackslash, 1'b0, 1'b0, NoWord},
    '{jsu_pkg::ChT,         1'b0, 1'b0, NoWord},
    '{jsu_pkg::ChBackslash, 1'b0, 1'b0, NoWord},
    '{jsu_pkg::ChBackslash, 1'b0, 1'b0, NoWord},
    '{jsu_pkg::ChBackslash, 1'b0, 1'b0, NoWord},
    '{jsu_pkg::ChQuote,     1'b0, 1'b0, NoWord},
    '{jsu_pkg::ChBackslash, 1'b0, 1'b0, NoWord},
    '{jsu_pkg::ChU,         1'b0, 1'b0, NoWord},
    '{"F",                  1'b0, 1'b0, NoWord},
    '{"f",                  1'b0, 1'b0, NoWord},
    '{"g",                  1'b0, 1'b0, NoWord},
    '{jsu_pkg::ChBackslash, 1'b1, 1'b0, NoWord},
    '{jsu_pkg::ChBackslash, 1'b1, 1'b1, TruncWord},
    '{jsu_pkg::ChBackslash, 1'b0, 1'b0, NoWord},
    '{8'h80,                1'b1, 1'b0, NoWord}
  };

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  jsu_in_if  in_ch ();
  jsu_out_if out_ch ();

  json_string_unescaper dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  result_word_t awaited_words [$];
  result_word_t step_words [jsu_pkg::MaxResults];
  int unsigned  failures      = 0;
  int unsigned  words_checked = 0;
  bit           steady_tail   = 1'b0;

  logic        esc_pending = 1'b0;
  logic        hex_active  = 1'b0;
  logic [2:0]  hex_count   = 3'd0;
  logic [15:0] cp_acc      = 16'h0000;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Advances the unescaping state by one byte and fills step_words with the words it yields.
  function automatic int unsigned unescape_byte(input logic [7:0] ch, input logic is_last);
    logic [7:0]  emit [jsu_pkg::MaxResults];
    logic [3:0]  nib;
    int unsigned n;
    int unsigned k;
    n   = 0;
    nib = 4'd0;
    if (hex_active) begin
      if (ch >= "0" && ch <= "9") begin
        nib = 4'(ch - "0");
      end else if (ch >= "A" && ch <= "F") begin
        nib = 4'(ch - "A") + jsu_pkg::HexTen;
      end else if (ch >= "a" && ch <= "f") begin
        nib = 4'(ch - "a") + jsu_pkg::HexTen;
      end
      cp_acc    = {cp_acc[11:0], nib};
      hex_count = hex_count + 3'd1;
      if (hex_count >= 3'd4) begin
        if (cp_acc < 16'h0080) begin
          emit[0] = cp_acc[7:0];
          n = 1;
        end else if (cp_acc < 16'h0800) begin
          emit[0] = 8'hC0 | 8'(cp_acc >> 6);
          emit[1] = 8'h80 | 8'(cp_acc & 16'h003F);
          n = 2;
        end else begin
          emit[0] = 8'hE0 | 8'(cp_acc >> 12);
          emit[1] = 8'h80 | 8'((cp_acc >> 6) & 16'h003F);
          emit[2] = 8'h80 | 8'(cp_acc & 16'h003F);
          n = 3;
        end
        hex_active = 1'b0;
        hex_count  = 3'd0;
        cp_acc     = 16'h0000;
      end
    end else if (esc_pending) begin
      esc_pending = 1'b0;
      if (ch == jsu_pkg::ChU) begin
        hex_active = 1'b1;
        hex_count  = 3'd0;
        cp_acc     = 16'h0000;
      end else begin
        case (ch)
          jsu_pkg::ChB: emit[0] = 8'h08;
          jsu_pkg::ChF: emit[0] = 8'h0C;
          jsu_pkg::ChN: emit[0] = 8'h0A;
          jsu_pkg::ChR: emit[0] = 8'h0D;
          jsu_pkg::ChT: emit[0] = 8'h09;
          default:      emit[0] = ch;
        endcase
        n = 1;
      end
    end else if (ch == jsu_pkg::ChBackslash) begin
      esc_pending = 1'b1;
    end else begin
      emit[0] = ch;
      n = 1;
    end
    for (k = 0; k < n; k++) begin
      step_words[k] = '{out_byte: emit[k], out_valid: 1'b1, out_last: is_last && (k + 1 == n),
                        truncated: 1'b0};
    end
    if (is_last) begin
      if (esc_pending || hex_active) begin
        step_words[n] = TruncWord;
        n++;
      end
      esc_pending = 1'b0;
      hex_active  = 1'b0;
      hex_count   = 3'd0;
      cp_acc      = 16'h0000;
    end
    return n;
  endfunction

  task automatic feed_byte(input logic [7:0] ch, input logic is_last, input logic typed,
                           input result_word_t typed_word);
    int unsigned gap;
    int unsigned n;
    int unsigned k;
    if (!steady_tail && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 14);
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid   <= 1'b1;
    in_ch.in_byte <= ch;
    in_ch.in_last <= is_last;
    do @(posedge clk_i); while (!in_ch.ready);
    n = unescape_byte(ch, is_last);
    if (typed) begin
      awaited_words.push_back(typed_word);
    end else begin
      for (k = 0; k < n; k++) begin
        awaited_words.push_back(step_words[k]);
      end
    end
  endtask

  initial begin : stimulus
    raw_word_t   random_stream [$];
    raw_word_t   tail_word;
    logic [7:0]  digit;
    logic [3:0]  nib;
    logic [15:0] cp;
    int unsigned seg_count;
    int unsigned s;
    int          d;
    int unsigned i;
    int unsigned drain;
    in_ch.valid   = 1'b0;
    in_ch.in_byte = 8'h00;
    in_ch.in_last = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Random strings are mostly well-formed escapes with random content.
    while (random_stream.size() < RandomItems) begin
      seg_count = $urandom_range(1, 6);
      for (s = 0; s < seg_count; s++) begin
        case ($urandom_range(0, 9))
          0, 1, 2: random_stream.push_back({8'($urandom), 1'b0});
          3, 4, 5: begin
            random_stream.push_back({jsu_pkg::ChBackslash, 1'b0});
            if ($urandom_range(0, 7) == 0) begin
              random_stream.push_back({8'($urandom), 1'b0});
            end else begin
              random_stream.push_back({EscapeLetters[$urandom_range(0, 6)], 1'b0});
            end
          end
          default: begin
            random_stream.push_back({jsu_pkg::ChBackslash, 1'b0});
            random_stream.push_back({jsu_pkg::ChU, 1'b0});
            case ($urandom_range(0, 3))
              0:       cp = 16'($urandom_range(16'h0000, 16'h007F));
              1:       cp = 16'($urandom_range(16'h0080, 16'h07FF));
              2:       cp = 16'($urandom_range(16'h0800, 16'hFFFF));
              default: cp = 16'($urandom);
            endcase
            for (d = 3; d >= 0; d--) begin
              nib = cp[4*d +: 4];
              if ($urandom_range(0, 11) == 0) begin
                digit = 8'($urandom);
              end else if (nib < jsu_pkg::HexTen) begin
                digit = "0" + nib;
              end else begin
                digit = ($urandom_range(0, 1) ? "A" : "a") + nib - jsu_pkg::HexTen;
              end
              random_stream.push_back({digit, 1'b0});
            end
          end
        endcase
      end
      // Some strings are cut off inside an escape.
      if ($urandom_range(0, 5) == 0) begin
        random_stream.push_back({jsu_pkg::ChBackslash, 1'b0});
        if ($urandom_range(0, 1) == 1) begin
          random_stream.push_back({jsu_pkg::ChU, 1'b0});
          repeat ($urandom_range(0, 3)) random_stream.push_back({8'($urandom), 1'b0});
        end
      end
      tail_word = random_stream.pop_back();
      tail_word.in_last = 1'b1;
      random_stream.push_back(tail_word);
    end

    foreach (DirectedRows[r]) begin
      feed_byte(DirectedRows[r].in_byte, DirectedRows[r].in_last, DirectedRows[r].typed,
                DirectedRows[r].typed_word);
    end

    in_ch.valid <= 1'b0;
    do @(posedge clk_i); while (awaited_words.size() != 0);

    for (i = 0; i < random_stream.size(); i++) begin
      if (i + TailItems >= random_stream.size()) begin
        steady_tail = 1'b1;
      end
      feed_byte(random_stream[i].in_byte, random_stream[i].in_last, 1'b0, NoWord);
    end

    in_ch.valid <= 1'b0;
    drain = 0;
    do begin
      @(posedge clk_i);
      drain++;
    end while (awaited_words.size() != 0 && drain < DrainLimit);
    repeat (10) @(posedge clk_i);
    if (awaited_words.size() != 0) begin
      $error("%0d expected words never arrived", awaited_words.size());
      failures++;
    end
    if (failures == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin : receiver
    int unsigned stall;
    bit          long_hold_done;
    long_hold_done = 1'b0;
    out_ch.ready   = 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      stall = 0;
      if (!long_hold_done && words_checked >= 60) begin
        long_hold_done = 1'b1;
        stall = LongHoldCycles;
      end else if (!steady_tail && $urandom_range(0, 3) == 0) begin
        stall = $urandom_range(1, 14);
      end
      if (stall != 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 24)) @(posedge clk_i);
    end
  end

  always @(posedge clk_i) begin : check_words
    result_word_t want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (awaited_words.size() == 0) begin
        $error("unexpected word: out_byte 8'h%02h, out_valid %0b, out_last %0b, truncated %0b",
               out_ch.out_byte, out_ch.out_valid, out_ch.out_last, out_ch.truncated);
        failures++;
      end else begin
        want = awaited_words.pop_front();
        words_checked++;
        if (out_ch.out_byte !== want.out_byte) begin
          $error("out_byte: expected 8'h%02h, got 8'h%02h", want.out_byte, out_ch.out_byte);
          failures++;
        end
        if (out_ch.out_valid !== want.out_valid) begin
          $error("out_valid: expected %0b, got %0b", want.out_valid, out_ch.out_valid);
          failures++;
        end
        if (out_ch.out_last !== want.out_last) begin
          $error("out_last: expected %0b, got %0b", want.out_last, out_ch.out_last);
          failures++;
        end
        if (out_ch.truncated !== want.truncated) begin
          $error("truncated: expected %0b, got %0b", want.truncated, out_ch.truncated);
          failures++;
        end
      end
    end
  end

  initial begin : watchdog
    #2_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
